// ===== src/bmm_pkg.sv =====
// bmm_pkg: shared types, codes, constants and mirror tables of the banked memory map
// no dependencies; imported by every module and used by the channel interfaces
package bmm_pkg;

    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 8;
    localparam int LATCH_W     = 8;
    localparam int FUNC_W      = 2;
    localparam int BANK_W      = 2;
    localparam int MODEL_W     = 2;
    localparam int SEG_W       = 3;
    localparam int OFF_W       = ADDR_W - SEG_W;
    localparam int SEG_CNT     = 1 << SEG_W;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ADDR_W-1:0] ROM_LOW_LIMIT   = 16'h6000;
    localparam logic [ADDR_W-1:0] ROM_SWITCH_ADDR = 16'hE000;
    localparam logic [ADDR_W-1:0] FLAT_WR_LIMIT   = 16'h4000;
    localparam logic [DATA_W-1:0] NO_BANK_BYTE    = 8'hFF;

    // register index of the one configuration register
    localparam logic [APB_ADDR_W-3:0] REG_MACHINE_MODEL = 1'b0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_READ    = 2'd0,
        FUNC_WRITE   = 2'd1,
        FUNC_PRELOAD = 2'd2,
        FUNC_NOP     = 2'd3
    } t_func;

    typedef enum logic [MODEL_W-1:0] {
        MODEL_FLAT = 2'd0,
        MODEL_48K  = 2'd1,
        MODEL_96K  = 2'd2,
        MODEL_128K = 2'd3
    } t_model;

    typedef enum logic [BANK_W-1:0] {
        BANK_ROM   = 2'd0,
        BANK_USER  = 2'd1,
        BANK_RB    = 2'd2,
        BANK_GREEN = 2'd3
    } t_bank;

    typedef enum logic [2:0] {
        SEL_NONE  = 3'd0,
        SEL_ROM   = 3'd1,
        SEL_USER  = 3'd2,
        SEL_RB    = 3'd3,
        SEL_GREEN = 3'd4
    } t_bank_sel;

    typedef struct packed {
        logic rom;
        logic user;
        logic rb;
        logic green;
    } t_bank_we;

    // one classified access, as it sits in the queue
    typedef struct packed {
        logic              is_read;
        logic              rom_forced;
        logic              rom_if_sw;
        t_bank_sel         alt;
        t_bank_we          we;
        logic [ADDR_W-1:0] addr_rom;
        logic [ADDR_W-1:0] addr_user;
        logic [ADDR_W-1:0] addr_vid;
        logic [DATA_W-1:0] wdata;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

    // segment increments of the mirror tables, added to address bits 15:13
    localparam logic [SEG_W-1:0] USER_RD_SEG [SEG_CNT] = '{
        3'd4, 3'd4, 3'd1, 3'd0, 3'd0, 3'd7, 3'd5, 3'd4
    };
    localparam logic [SEG_W-1:0] USER_WR_SEG [SEG_CNT] = '{
        3'd4, 3'd3, 3'd1, 3'd0, 3'd0, 3'd7, 3'd5, 3'd4
    };
    localparam logic [SEG_W-1:0] VIDEO_SEG [SEG_CNT] = '{
        3'd5, 3'd4, 3'd4, 3'd3, 3'd1, 3'd0, 3'd0, 3'd7
    };

    function automatic logic [ADDR_W-1:0] mirror_addr(
        input logic [ADDR_W-1:0] a,
        input logic [SEG_W-1:0]  inc
    );
        logic [SEG_W-1:0] seg;
        seg = a[ADDR_W-1:OFF_W] + inc;
        return {seg, a[OFF_W-1:0]};
    endfunction

endpackage

// ===== src/bmm_if.sv =====
// bmm_if: request and response channel interfaces of the banked memory map
// depends on bmm_pkg for field widths
interface bmm_req_if;
    logic                         valid;
    logic                         ready;
    logic [bmm_pkg::FUNC_W-1:0]   func;
    logic [bmm_pkg::ADDR_W-1:0]   address;
    logic [bmm_pkg::DATA_W-1:0]   write_data;
    logic [bmm_pkg::LATCH_W-1:0]  bank_ctl;
    logic [bmm_pkg::LATCH_W-1:0]  video_ctl;
    logic [bmm_pkg::BANK_W-1:0]   preload_bank;

    modport source (
        output valid, func, address, write_data, bank_ctl, video_ctl, preload_bank,
        input  ready
    );
    modport sink (
        input  valid, func, address, write_data, bank_ctl, video_ctl, preload_bank,
        output ready
    );
endinterface

interface bmm_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [bmm_pkg::DATA_W-1:0]  read_data;
    logic                        mapped;

    modport source (
        output valid, read_data, mapped,
        input  ready
    );
    modport sink (
        input  valid, read_data, mapped,
        output ready
    );
endinterface

// ===== src/bmm_front.sv =====
// bmm_front: takes requests and classifies them into bank selects, enables and addresses
// depends on bmm_pkg and bmm_req_if
module bmm_front (
    bmm_req_if.sink              i_req,
    input  bmm_pkg::t_model      i_model,
    input  bmm_pkg::t_queue_stat i_qstat,
    output logic                 o_push,
    output bmm_pkg::t_entry      o_entry
);
    import bmm_pkg::*;

    logic [ADDR_W-1:0]  a;
    logic [LATCH_W-1:0] bl;
    logic [LATCH_W-1:0] vl;
    logic [SEG_W-1:0]   seg;
    logic [ADDR_W-1:0]  mir_user_rd;
    logic [ADDR_W-1:0]  mir_user_wr;
    logic [ADDR_W-1:0]  mir_vid;
    t_entry             ent;

    assign i_req.ready = !i_qstat.full;
    assign o_push      = i_req.valid && !i_qstat.full;
    assign o_entry     = ent;

    assign a   = i_req.address;
    assign bl  = i_req.bank_ctl;
    assign vl  = i_req.video_ctl;
    assign seg = a[ADDR_W-1:OFF_W];

    assign mir_user_rd = mirror_addr(a, USER_RD_SEG[seg]);
    assign mir_user_wr = mirror_addr(a, USER_WR_SEG[seg]);
    assign mir_vid     = mirror_addr(a, VIDEO_SEG[seg]);

    always_comb begin
        ent            = '0;
        ent.alt        = SEL_NONE;
        ent.addr_rom   = a;
        ent.addr_user  = a;
        ent.addr_vid   = a;
        ent.wdata      = i_req.write_data;
        case (t_func'(i_req.func))
            FUNC_READ: begin
                ent.is_read = 1'b1;
                case (i_model)
                    MODEL_FLAT: begin
                        ent.rom_forced = 1'b1;
                    end
                    MODEL_128K: begin
                        ent.rom_forced = !bl[3] && (a < ROM_LOW_LIMIT);
                        ent.rom_if_sw  = !bl[3];
                        if (bl[1]) begin
                            ent.alt = SEL_RB;
                        end else if (!bl[2]) begin
                            ent.alt = SEL_USER;
                        end
                    end
                    default: begin
                        ent.rom_forced = !bl[4] && (a < ROM_LOW_LIMIT);
                        ent.rom_if_sw  = !bl[4] && (a >= ROM_SWITCH_ADDR);
                        ent.addr_user  = (i_model == MODEL_96K) ? a : mir_user_rd;
                        ent.addr_vid   = mir_vid;
                        if (!bl[5]) begin
                            ent.alt = SEL_USER;
                        end else if (bl[6] && !vl[2]) begin
                            ent.alt = SEL_RB;
                        end else if (bl[6] && !vl[3]) begin
                            ent.alt = SEL_GREEN;
                        end
                    end
                endcase
            end
            FUNC_WRITE: begin
                case (i_model)
                    MODEL_FLAT: begin
                        ent.we.rom = (a >= FLAT_WR_LIMIT);
                    end
                    MODEL_128K: begin
                        ent.we.user = !bl[7];
                        ent.we.rb   = bl[6];
                    end
                    default: begin
                        ent.addr_user = (i_model == MODEL_96K) ? a : mir_user_wr;
                        ent.addr_vid  = mir_vid;
                        ent.we.user   = !bl[0];
                        ent.we.rb     = bl[1] && !vl[2];
                        ent.we.green  = bl[2] && !vl[3];
                    end
                endcase
            end
            FUNC_PRELOAD: begin
                case (t_bank'(i_req.preload_bank))
                    BANK_ROM:   ent.we.rom   = 1'b1;
                    BANK_USER:  ent.we.user  = 1'b1;
                    BANK_RB:    ent.we.rb    = 1'b1;
                    BANK_GREEN: ent.we.green = 1'b1;
                    default:    ent.we       = '0;
                endcase
            end
            default: begin
                ent.is_read = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/bmm_fifo.sv =====
// bmm_fifo: short queue of classified accesses between front and back
// depends on bmm_pkg
module bmm_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  bmm_pkg::t_entry      i_entry,
    input  logic                 i_pop,
    output bmm_pkg::t_entry      o_entry,
    output bmm_pkg::t_queue_stat o_stat
);
    import bmm_pkg::*;

    t_entry                 r_slot [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count, n_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_stat.full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_entry      = r_slot[r_rd_ptr];

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + QUEUE_CNT_W'(do_push) - QUEUE_CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== src/bmm_back.sv =====
// bmm_back: the four bank memories, rom switch tracking, read select and response register
// depends on bmm_pkg and bmm_rsp_if
module bmm_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bmm_pkg::t_entry      i_entry,
    input  bmm_pkg::t_queue_stat i_qstat,
    output logic                 o_pop,
    bmm_rsp_if.source            o_rsp
);
    import bmm_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_rom_mem   [DEPTH];
    logic [DATA_W-1:0] r_user_mem  [DEPTH];
    logic [DATA_W-1:0] r_rb_mem    [DEPTH];
    logic [DATA_W-1:0] r_green_mem [DEPTH];

    logic [DATA_W-1:0] r_rom_rd;
    logic [DATA_W-1:0] r_user_rd;
    logic [DATA_W-1:0] r_rb_rd;
    logic [DATA_W-1:0] r_green_rd;

    logic              r_rom_sw;
    logic              r_a_valid;
    logic              r_a_read;
    t_bank_sel         r_a_sel;
    t_bank_sel         n_a_sel;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data, n_out_data;
    logic              r_out_mapped, n_out_mapped;
    logic              out_free;
    logic              a_free;
    logic              pop;
    logic              sw_write;

    assign out_free = !r_out_valid || o_rsp.ready;
    assign a_free   = !r_a_valid || out_free;
    assign pop      = !i_qstat.empty && a_free;
    assign o_pop    = pop;

    assign sw_write = pop && i_entry.we.rom && (i_entry.addr_rom == ROM_SWITCH_ADDR);

    // rom answers when forced, or in the switched region while rom byte 0xE000 is not 0xff
    always_comb begin
        n_a_sel = SEL_NONE;
        if (i_entry.is_read) begin
            if (i_entry.rom_forced || (i_entry.rom_if_sw && r_rom_sw)) begin
                n_a_sel = SEL_ROM;
            end else begin
                n_a_sel = i_entry.alt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (i_entry.we.rom) begin
                r_rom_mem[i_entry.addr_rom] <= i_entry.wdata;
            end else begin
                r_rom_rd <= r_rom_mem[i_entry.addr_rom];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (i_entry.we.user) begin
                r_user_mem[i_entry.addr_user] <= i_entry.wdata;
            end else begin
                r_user_rd <= r_user_mem[i_entry.addr_user];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (i_entry.we.rb) begin
                r_rb_mem[i_entry.addr_vid] <= i_entry.wdata;
            end else begin
                r_rb_rd <= r_rb_mem[i_entry.addr_vid];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (i_entry.we.green) begin
                r_green_mem[i_entry.addr_vid] <= i_entry.wdata;
            end else begin
                r_green_rd <= r_green_mem[i_entry.addr_vid];
            end
        end
    end

    always_comb begin
        n_out_data   = '0;
        n_out_mapped = 1'b0;
        if (r_a_read) begin
            n_out_mapped = 1'b1;
            case (r_a_sel)
                SEL_ROM:   n_out_data = r_rom_rd;
                SEL_USER:  n_out_data = r_user_rd;
                SEL_RB:    n_out_data = r_rb_rd;
                SEL_GREEN: n_out_data = r_green_rd;
                default: begin
                    n_out_data   = NO_BANK_BYTE;
                    n_out_mapped = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_sw    <= 1'b1;
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (sw_write) begin
                r_rom_sw <= (i_entry.wdata != NO_BANK_BYTE);
            end
            if (a_free) begin
                r_a_valid <= pop;
            end
            if (out_free) begin
                r_out_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_a_read <= i_entry.is_read;
            r_a_sel  <= n_a_sel;
        end
        if (out_free) begin
            r_out_data   <= n_out_data;
            r_out_mapped <= n_out_mapped;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_data = r_out_data;
    assign o_rsp.mapped    = r_out_mapped;

`ifndef SYNTHESIS
    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !out_free |=> r_a_valid && $stable(r_a_sel))
        else $error("memory stage lost or changed while the response stalled");

    a_rom_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sw_write |=> r_rom_sw == ($past(i_entry.wdata) != NO_BANK_BYTE))
        else $error("rom switch flag does not follow the write to 0xe000");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_free && r_a_valid && !r_a_read |=> !r_out_mapped && r_out_data == '0)
        else $error("non-read access produced read data");

    a_no_pop_on_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !out_free |-> !pop)
        else $error("queue popped while the memory stage was held");
`endif

endmodule

// ===== src/banked_memory_map.sv =====
// banked_memory_map: top level, apb machine model register, front, queue and back
// depends on bmm_pkg, bmm_req_if, bmm_rsp_if, bmm_front, bmm_fifo, bmm_back
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+-----------------------------------------------
//  i_req    | in  | valid/ready      | func, address, write_data, bank_ctl,
//           |     |                  | video_ctl, preload_bank
//  o_rsp    | out | valid/ready      | read_data, mapped
//  apb      | in  | psel/penable     | paddr, pwdata, prdata (machine_model at 0x0)
//
// one transfer per cycle on both sides while o_rsp is not stalled, set by the single-port bank memories
// an accepted request passes the queue, the memory stage (the memories are read as it is
// popped) and the response register, in that order, before it is offered on o_rsp
// reset empties the queue, drops the pipeline valids, sets the rom switch flag and
// loads the 48k model; bank memories are not cleared and hold garbage until written
// a stalled response holds the memory stage, then the queue fills and i_req.ready drops
module banked_memory_map (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    bmm_req_if.sink                             i_req,
    bmm_rsp_if.source                           o_rsp,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bmm_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [bmm_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [bmm_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import bmm_pkg::*;

    t_model      r_model;
    logic        cfg_wr;
    logic        q_push;
    logic        q_pop;
    t_entry      q_in;
    t_entry      q_out;
    t_queue_stat q_stat;

    // apb: no wait states, register index taken from the word address
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[APB_ADDR_W-1:2] == REG_MACHINE_MODEL);

    always_comb begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1:2] == REG_MACHINE_MODEL) begin
            prdata = {{(APB_DATA_W-MODEL_W){1'b0}}, r_model};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model <= MODEL_48K;
        end else if (cfg_wr) begin
            r_model <= t_model'(pwdata[MODEL_W-1:0]);
        end
    end

    // front: classify each request against the current model
    bmm_front u_front (
        .i_req   (i_req),
        .i_model (r_model),
        .i_qstat (q_stat),
        .o_push  (q_push),
        .o_entry (q_in)
    );

    // queue decouples request acceptance from memory access
    bmm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_entry (q_out),
        .o_stat  (q_stat)
    );

    // back: bank memories and response register
    bmm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (q_out),
        .i_qstat (q_stat),
        .o_pop   (q_pop),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking bench for banked_memory_map, with a stimulus queue, a
// transfer driver, an in-order response checker and a byte-level predictor of the four stores
// depends on bmm_pkg, bmm_req_if, bmm_rsp_if and banked_memory_map
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bmm_pkg::*;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int PHASE_COUNT   = 8;
    localparam int RANDOM_ITEMS  = 42;
    localparam int MAX_PAUSE     = 11;
    localparam int SETTLE_CYCLES = 8;

    localparam logic [APB_ADDR_W-1:0] MODEL_REG_ADDR = {REG_MACHINE_MODEL, 2'b00};

    // machine model of each phase; both extremes, every model twice
    localparam t_model PHASE_MODELS [PHASE_COUNT] = '{
        MODEL_48K, MODEL_FLAT, MODEL_128K, MODEL_96K,
        MODEL_FLAT, MODEL_48K, MODEL_128K, MODEL_96K
    };

    // offsets added per 8k segment, wrapping at 64k
    localparam logic [ADDR_W-1:0] USER_RD_STEP [8] = '{
        16'h8000, 16'h8000, 16'h2000, 16'h0000, 16'h0000, 16'hE000, 16'hA000, 16'h8000
    };
    localparam logic [ADDR_W-1:0] USER_WR_STEP [8] = '{
        16'h8000, 16'h6000, 16'h2000, 16'h0000, 16'h0000, 16'hE000, 16'hA000, 16'h8000
    };
    localparam logic [ADDR_W-1:0] VIDEO_STEP [8] = '{
        16'hA000, 16'h8000, 16'h8000, 16'h6000, 16'h2000, 16'h0000, 16'h0000, 16'hE000
    };

    typedef struct packed {
        t_func              func;
        logic [ADDR_W-1:0]  address;
        logic [DATA_W-1:0]  write_data;
        logic [LATCH_W-1:0] bank_ctl;
        logic [LATCH_W-1:0] video_ctl;
        t_bank              preload_bank;
    } t_access;

    typedef struct packed {
        bit [DATA_W-1:0] data;
        bit              mapped;
    } t_reply;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bmm_req_if req_ch ();
    bmm_rsp_if rsp_ch ();

    banked_memory_map dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // accesses waiting to be driven, in order
    t_access access_q [$];
    // replies owed by the block, oldest first
    t_reply  reply_q [$];

    // predicted contents of the four stores, keyed by {bank, offset}
    bit [DATA_W-1:0] store_image [bit [BANK_W+ADDR_W-1:0]];
    t_model          model_reg = MODEL_48K;

    // stimulus side bookkeeping: which entries hold a value, and the rom switch byte
    bit              filled [bit [BANK_W+ADDR_W-1:0]];
    t_model          plan_model = MODEL_48K;
    logic [DATA_W-1:0] plan_switch_byte;

    logic [12:0] offset_pool [8];

    bit req_fire = 1'b0;
    bit rsp_fire = 1'b0;
    int cycle_count = 0;
    int error_count = 0;

    // handshake pacing state, touched only by the driver blocks
    int req_wait = 0;
    int rsp_stall = 0;
    bit req_calm = 1'b0;
    bit rsp_calm = 1'b0;

    // ------------------------------------------------------------------
    // routing: which bank answers or takes a byte, and at which offset
    // ------------------------------------------------------------------

    function automatic t_bank bank_of(input t_bank_sel sel);
        case (sel)
            SEL_USER:  return BANK_USER;
            SEL_RB:    return BANK_RB;
            SEL_GREEN: return BANK_GREEN;
            default:   return BANK_ROM;
        endcase
    endfunction

    function automatic t_bank_sel read_route(
        input  t_model             model,
        input  logic [ADDR_W-1:0]  a,
        input  logic [LATCH_W-1:0] bl,
        input  logic [LATCH_W-1:0] vl,
        input  bit                 rom_on,
        output logic [ADDR_W-1:0]  off
    );
        off = a;
        case (model)
            MODEL_FLAT: begin
                return SEL_ROM;
            end
            MODEL_128K: begin
                // rom low area, or anywhere once the switch byte is live
                if (!bl[3] && (a < ROM_LOW_LIMIT || rom_on))
                    return SEL_ROM;
                if (bl[1])
                    return SEL_RB;
                if (!bl[2])
                    return SEL_USER;
                return SEL_NONE;
            end
            default: begin
                if (!bl[4] && (a < ROM_LOW_LIMIT || (a >= ROM_SWITCH_ADDR && rom_on)))
                    return SEL_ROM;
                if (!bl[5]) begin
                    if (model == MODEL_48K)
                        off = a + USER_RD_STEP[a[15:13]];
                    return SEL_USER;
                end
                if (bl[6]) begin
                    off = a + VIDEO_STEP[a[15:13]];
                    if (!vl[2])
                        return SEL_RB;
                    if (!vl[3])
                        return SEL_GREEN;
                end
                return SEL_NONE;
            end
        endcase
    endfunction

    function automatic void write_route(
        input  t_model                   model,
        input  logic [ADDR_W-1:0]        a,
        input  logic [LATCH_W-1:0]       bl,
        input  logic [LATCH_W-1:0]       vl,
        output bit [3:0]                 en,
        output logic [3:0][ADDR_W-1:0]   offs
    );
        en = '0;
        for (int b = 0; b < 4; b++)
            offs[b] = a;
        case (model)
            MODEL_FLAT: begin
                en[BANK_ROM] = (a >= FLAT_WR_LIMIT);
            end
            MODEL_128K: begin
                en[BANK_USER] = !bl[7];
                en[BANK_RB]   = bl[6];
            end
            default: begin
                // write mirror differs from the read one in the 0x2000 segment
                en[BANK_USER] = !bl[0];
                if (model == MODEL_48K)
                    offs[BANK_USER] = a + USER_WR_STEP[a[15:13]];
                en[BANK_RB]      = bl[1] && !vl[2];
                en[BANK_GREEN]   = bl[2] && !vl[3];
                offs[BANK_RB]    = a + VIDEO_STEP[a[15:13]];
                offs[BANK_GREEN] = a + VIDEO_STEP[a[15:13]];
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // predictor: applies one accepted access and queues the reply it owes
    // ------------------------------------------------------------------

    task automatic apply_access(input t_access acc);
        t_reply                  r;
        t_bank_sel               sel;
        logic [ADDR_W-1:0]       off;
        bit [3:0]                en;
        logic [3:0][ADDR_W-1:0]  offs;
        r = '0;
        case (acc.func)
            FUNC_READ: begin
                sel = read_route(model_reg, acc.address, acc.bank_ctl, acc.video_ctl,
                                 store_image[{BANK_ROM, ROM_SWITCH_ADDR}] != NO_BANK_BYTE,
                                 off);
                if (sel == SEL_NONE) begin
                    r.data   = NO_BANK_BYTE;
                    r.mapped = 1'b0;
                end else begin
                    r.data   = store_image[{bank_of(sel), off}];
                    r.mapped = 1'b1;
                end
            end
            FUNC_WRITE: begin
                write_route(model_reg, acc.address, acc.bank_ctl, acc.video_ctl, en, offs);
                for (int b = 0; b < 4; b++)
                    if (en[b])
                        store_image[{2'(b), offs[b]}] = acc.write_data;
            end
            FUNC_PRELOAD: begin
                store_image[{acc.preload_bank, acc.address}] = acc.write_data;
            end
            default: ;  // unused code: nothing changes, zero reply
        endcase
        reply_q.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // stimulus planning
    // ------------------------------------------------------------------

    function automatic t_access make_access(
        input t_func              f,
        input logic [ADDR_W-1:0]  a,
        input logic [DATA_W-1:0]  d,
        input logic [LATCH_W-1:0] bl,
        input logic [LATCH_W-1:0] vl,
        input t_bank              pb
    );
        t_access acc;
        acc.func         = f;
        acc.address      = a;
        acc.write_data   = d;
        acc.bank_ctl     = bl;
        acc.video_ctl    = vl;
        acc.preload_bank = pb;
        return acc;
    endfunction

    task automatic note_store(input t_bank b, input logic [ADDR_W-1:0] a,
                              input logic [DATA_W-1:0] d);
        filled[{b, a}] = 1'b1;
        if (b == BANK_ROM && a == ROM_SWITCH_ADDR)
            plan_switch_byte = d;
    endtask

    // queues an access; a read that would land on a never-written entry gets a
    // preload of that entry with random data just ahead of it
    task automatic queue_access(input t_access acc);
        t_bank_sel               sel;
        logic [ADDR_W-1:0]       off;
        bit [3:0]                en;
        logic [3:0][ADDR_W-1:0]  offs;
        t_access                 fill;
        case (acc.func)
            FUNC_READ: begin
                sel = read_route(plan_model, acc.address, acc.bank_ctl, acc.video_ctl,
                                 plan_switch_byte != NO_BANK_BYTE, off);
                if (sel != SEL_NONE && !filled.exists({bank_of(sel), off})) begin
                    fill = make_access(FUNC_PRELOAD, off, 8'($urandom), 8'($urandom),
                                       8'($urandom), bank_of(sel));
                    note_store(fill.preload_bank, off, fill.write_data);
                    access_q.push_back(fill);
                end
            end
            FUNC_WRITE: begin
                write_route(plan_model, acc.address, acc.bank_ctl, acc.video_ctl,
                            en, offs);
                for (int b = 0; b < 4; b++)
                    if (en[b])
                        note_store(t_bank'(b), offs[b], acc.write_data);
            end
            FUNC_PRELOAD: begin
                note_store(acc.preload_bank, acc.address, acc.write_data);
            end
            default: ;
        endcase
        access_q.push_back(acc);
    endtask

    // idle length for one transfer; calm stretches run with no idling at all
    function automatic int draw_pause(input bit calm);
        return calm ? 0 : $urandom_range(0, MAX_PAUSE);
    endfunction

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------

    task automatic apb_access(input bit wr, input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= MODEL_REG_ADDR;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_model_reg();
        logic [APB_DATA_W-1:0] word;
        apb_access(1'b0, '0, word);
        if (word[MODEL_W-1:0] !== model_reg) begin
            $display("%0t: machine_model readback expected %0d got %0d",
                     $time, model_reg, word[MODEL_W-1:0]);
            error_count++;
        end
    endtask

    // wait until every queued access went out and every reply came back
    task automatic wait_idle();
        while (access_q.size() != 0 || req_ch.valid || reply_q.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // request driver: changes at the falling edge, fed from access_q
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        t_access nxt;
        if (i_rst_n) begin
            // the bus is free when nothing is up or the item just went across
            if (req_fire || !req_ch.valid) begin
                if (req_fire) begin
                    if ($urandom_range(0, 15) == 0)
                        req_calm = !req_calm;
                    req_wait = draw_pause(req_calm);
                end
                if (req_wait == 0 && access_q.size() != 0) begin
                    nxt = access_q.pop_front();
                    req_ch.valid        <= 1'b1;
                    req_ch.func         <= nxt.func;
                    req_ch.address      <= nxt.address;
                    req_ch.write_data   <= nxt.write_data;
                    req_ch.bank_ctl     <= nxt.bank_ctl;
                    req_ch.video_ctl    <= nxt.video_ctl;
                    req_ch.preload_bank <= nxt.preload_bank;
                end else begin
                    req_ch.valid <= 1'b0;
                    if (req_wait > 0)
                        req_wait--;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // response ready: a random stall after each response transfer
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_fire) begin
                if ($urandom_range(0, 15) == 0)
                    rsp_calm = !rsp_calm;
                rsp_stall = draw_pause(rsp_calm);
            end
            if (rsp_stall > 0) begin
                rsp_ch.ready <= 1'b0;
                rsp_stall--;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: samples both channels at the rising edge
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_reply want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d accesses and %0d replies still pending",
                     $time, access_q.size(), reply_q.size());
            $display("== FAIL ==");
            $finish;
        end else begin
            req_fire <= i_rst_n && req_ch.valid && req_ch.ready;
            rsp_fire <= i_rst_n && rsp_ch.valid && rsp_ch.ready;
            // request transfer: predict its reply from the bus payload
            if (i_rst_n && req_ch.valid && req_ch.ready)
                apply_access(make_access(t_func'(req_ch.func), req_ch.address,
                                         req_ch.write_data, req_ch.bank_ctl,
                                         req_ch.video_ctl, t_bank'(req_ch.preload_bank)));
            // response transfer: compare against the oldest owed reply
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                if (reply_q.size() == 0) begin
                    $display("%0t: unexpected response read_data %02h mapped %0d",
                             $time, rsp_ch.read_data, rsp_ch.mapped);
                    error_count++;
                end else begin
                    want = reply_q.pop_front();
                    if (rsp_ch.read_data !== want.data) begin
                        $display("%0t: read_data expected %02h got %02h",
                                 $time, want.data, rsp_ch.read_data);
                        error_count++;
                    end
                    if (rsp_ch.mapped !== want.mapped) begin
                        $display("%0t: mapped expected %0d got %0d",
                                 $time, want.mapped, rsp_ch.mapped);
                        error_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence: reset, then per phase a model write and a batch of accesses
    // ------------------------------------------------------------------

    initial begin
        logic [APB_DATA_W-1:0] word;
        t_access               acc;
        int                    pick;

        // every input known from time zero
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        req_ch.valid        = 1'b0;
        req_ch.func         = '0;
        req_ch.address      = '0;
        req_ch.write_data   = '0;
        req_ch.bank_ctl     = '0;
        req_ch.video_ctl    = '0;
        req_ch.preload_bank = '0;
        rsp_ch.ready        = 1'b0;

        // a few offsets shared by all segments so that mirrored accesses collide
        foreach (offset_pool[k])
            offset_pool[k] = 13'($urandom);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // register comes out of reset as the 48k model
        check_model_reg();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            wait_idle();
            apb_access(1'b1, APB_DATA_W'(PHASE_MODELS[p]), word);
            model_reg  = PHASE_MODELS[p];
            plan_model = PHASE_MODELS[p];
            check_model_reg();

            if (p == 0) begin
                // rom switch byte first, so the switch test never sees an empty entry
                queue_access(make_access(FUNC_PRELOAD, ROM_SWITCH_ADDR, 8'h00, 8'h00, 8'h00,
                                         BANK_ROM));
                queue_access(make_access(FUNC_PRELOAD, 16'h0000, 8'hA5, 8'h00, 8'h00,
                                         BANK_ROM));
                queue_access(make_access(FUNC_READ, 16'h0000, 8'h00, 8'h00, 8'hFF, BANK_ROM));
                // 0x2000 segment: write lands at 0x8000, read comes from 0xA000
                queue_access(make_access(FUNC_WRITE, 16'h2000, 8'h3C, 8'h00, 8'hFF, BANK_ROM));
                queue_access(make_access(FUNC_PRELOAD, 16'hA000, 8'h5A, 8'h00, 8'h00,
                                         BANK_USER));
                queue_access(make_access(FUNC_READ, 16'h2000, 8'h00, 8'h10, 8'hFF, BANK_ROM));
                queue_access(make_access(FUNC_READ, 16'h8000, 8'h00, 8'h10, 8'hFF, BANK_ROM));
                // top of rom with the switch live, then switched off
                queue_access(make_access(FUNC_PRELOAD, 16'hFFFF, 8'hFF, 8'h00, 8'h00,
                                         BANK_ROM));
                queue_access(make_access(FUNC_READ, 16'hFFFF, 8'h00, 8'h00, 8'hFF, BANK_ROM));
                queue_access(make_access(FUNC_PRELOAD, ROM_SWITCH_ADDR, 8'hFF, 8'h00, 8'h00,
                                         BANK_ROM));
                queue_access(make_access(FUNC_READ, 16'hFFFF, 8'h00, 8'h00, 8'hFF, BANK_ROM));
                // nothing answers
                queue_access(make_access(FUNC_READ, 16'hFFFF, 8'h00, 8'h70, 8'hFF, BANK_ROM));
                queue_access(make_access(FUNC_READ, ROM_SWITCH_ADDR, 8'h00, 8'h20, 8'hFF,
                                         BANK_ROM));
                // all bank latch bits set, video latch clear: user off, both video banks take the byte
                queue_access(make_access(FUNC_WRITE, 16'hFFFF, 8'h00, 8'hFF, 8'h00, BANK_ROM));
                queue_access(make_access(FUNC_READ, 16'hFFFF, 8'h00, 8'h60, 8'h00, BANK_ROM));
                queue_access(make_access(FUNC_READ, 16'hFFFF, 8'h00, 8'h60, 8'hF7, BANK_ROM));
                queue_access(make_access(FUNC_READ, 16'hFFFF, 8'h00, 8'hFF, 8'hFF, BANK_ROM));
                // unused function code with every field at its top
                queue_access(make_access(FUNC_NOP, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, BANK_GREEN));
                queue_access(make_access(FUNC_PRELOAD, ROM_SWITCH_ADDR, 8'h00, 8'h00, 8'h00,
                                         BANK_ROM));
            end

            repeat (RANDOM_ITEMS) begin
                // mostly pooled offsets in any segment, some corners, some fully random
                pick = $urandom_range(0, 9);
                if (pick < 2)
                    acc.address = 16'($urandom);
                else if (pick == 2)
                    case ($urandom_range(0, 5))
                        0:       acc.address = 16'h0000;
                        1:       acc.address = 16'hFFFF;
                        2:       acc.address = ROM_LOW_LIMIT - 16'd1;
                        3:       acc.address = ROM_LOW_LIMIT;
                        4:       acc.address = ROM_SWITCH_ADDR - 16'd1;
                        default: acc.address = ROM_SWITCH_ADDR;
                    endcase
                else
                    acc.address = {3'($urandom_range(0, 7)), offset_pool[$urandom_range(0, 7)]};
                acc.write_data   = 8'($urandom);
                acc.bank_ctl     = 8'($urandom);
                acc.video_ctl    = 8'($urandom);
                acc.preload_bank = t_bank'($urandom_range(0, 3));
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    acc.func = FUNC_READ;
                end else if (pick < 75) begin
                    acc.func = FUNC_WRITE;
                end else if (pick < 95) begin
                    acc.func = FUNC_PRELOAD;
                    // now and then flip the rom switch byte
                    if ($urandom_range(0, 7) == 0) begin
                        acc.address      = ROM_SWITCH_ADDR;
                        acc.preload_bank = BANK_ROM;
                        if ($urandom_range(0, 1) == 0)
                            acc.write_data = NO_BANK_BYTE;
                    end
                end else begin
                    acc.func = FUNC_NOP;
                end
                queue_access(acc);
            end
        end

        wait_idle();
        // give a stray extra response time to show up
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
src/bmm_pkg.sv
src/bmm_if.sv
src/bmm_front.sv
src/bmm_fifo.sv
src/bmm_back.sv
src/banked_memory_map.sv
tb/testbench.sv
